FILE: src/sta_pkg.sv
// package for the scancode to ascii translator
// holds command types, key codes and the us layout lookups; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sta_pkg;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // scancodes
    localparam logic [7:0] SC_PREFIX = 8'hE0;
    localparam logic [6:0] SC_LSHIFT = 7'h2A;
    localparam logic [6:0] SC_RSHIFT = 7'h36;
    localparam logic [6:0] SC_CAPS   = 7'h3A;
    localparam logic [6:0] SC_UP     = 7'h48;
    localparam logic [6:0] SC_DOWN   = 7'h50;
    localparam logic [6:0] SC_RIGHT  = 7'h4D;
    localparam logic [6:0] SC_LEFT   = 7'h4B;

    // characters
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_B  = 8'h42;
    localparam logic [7:0] CH_UPPER_C  = 8'h43;
    localparam logic [7:0] CH_UPPER_D  = 8'h44;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    typedef enum logic [1:0] {
        KIND_CHAR,
        KIND_BS,
        KIND_ARROW
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] ch;
    } cmd_t;

    typedef logic [1:0] step_t;

    function automatic logic [7:0] plain_char(input logic [6:0] key);
        case (key)
            7'h01: return 8'h60;
            7'h02: return 8'h31;
            7'h03: return 8'h32;
            7'h04: return 8'h33;
            7'h05: return 8'h34;
            7'h06: return 8'h35;
            7'h07: return 8'h36;
            7'h08: return 8'h37;
            7'h09: return 8'h38;
            7'h0A: return 8'h39;
            7'h0B: return 8'h30;
            7'h0C: return 8'h2D;
            7'h0D: return 8'h3D;
            7'h0E: return 8'h08;
            7'h0F: return 8'h09;
            7'h10: return 8'h71;
            7'h11: return 8'h77;
            7'h12: return 8'h65;
            7'h13: return 8'h72;
            7'h14: return 8'h74;
            7'h15: return 8'h79;
            7'h16: return 8'h75;
            7'h17: return 8'h69;
            7'h18: return 8'h6F;
            7'h19: return 8'h70;
            7'h1A: return 8'h5B;
            7'h1B: return 8'h5D;
            7'h1C: return 8'h0A;
            7'h1E: return 8'h61;
            7'h1F: return 8'h73;
            7'h20: return 8'h64;
            7'h21: return 8'h66;
            7'h22: return 8'h67;
            7'h23: return 8'h68;
            7'h24: return 8'h6A;
            7'h25: return 8'h6B;
            7'h26: return 8'h6C;
            7'h27: return 8'h3B;
            7'h28: return 8'h27;
            7'h29: return 8'h60;
            7'h2B: return 8'h5C;
            7'h2C: return 8'h7A;
            7'h2D: return 8'h78;
            7'h2E: return 8'h63;
            7'h2F: return 8'h76;
            7'h30: return 8'h62;
            7'h31: return 8'h6E;
            7'h32: return 8'h6D;
            7'h33: return 8'h2C;
            7'h34: return 8'h2E;
            7'h35: return 8'h2F;
            7'h37: return 8'h2A;
            7'h39: return 8'h20;
            7'h4A: return 8'h2D;
            7'h4E: return 8'h2B;
            default: return CH_NUL;
        endcase
    endfunction

    function automatic logic [7:0] shifted_char(input logic [6:0] key);
        case (key)
            7'h01: return 8'h7E;
            7'h02: return 8'h21;
            7'h03: return 8'h40;
            7'h04: return 8'h23;
            7'h05: return 8'h24;
            7'h06: return 8'h25;
            7'h07: return 8'h5E;
            7'h08: return 8'h26;
            7'h09: return 8'h2A;
            7'h0A: return 8'h28;
            7'h0B: return 8'h29;
            7'h0C: return 8'h5F;
            7'h0D: return 8'h2B;
            7'h0E: return 8'h08;
            7'h0F: return 8'h09;
            7'h10: return 8'h51;
            7'h11: return 8'h57;
            7'h12: return 8'h45;
            7'h13: return 8'h52;
            7'h14: return 8'h54;
            7'h15: return 8'h59;
            7'h16: return 8'h55;
            7'h17: return 8'h49;
            7'h18: return 8'h4F;
            7'h19: return 8'h50;
            7'h1A: return 8'h7B;
            7'h1B: return 8'h7D;
            7'h1C: return 8'h0A;
            7'h1E: return 8'h41;
            7'h1F: return 8'h53;
            7'h20: return 8'h44;
            7'h21: return 8'h46;
            7'h22: return 8'h47;
            7'h23: return 8'h48;
            7'h24: return 8'h4A;
            7'h25: return 8'h4B;
            7'h26: return 8'h4C;
            7'h27: return 8'h3A;
            7'h28: return 8'h22;
            7'h29: return 8'h60;
            7'h2B: return 8'h7C;
            7'h2C: return 8'h5A;
            7'h2D: return 8'h58;
            7'h2E: return 8'h43;
            7'h2F: return 8'h56;
            7'h30: return 8'h42;
            7'h31: return 8'h4E;
            7'h32: return 8'h4D;
            7'h33: return 8'h3C;
            7'h34: return 8'h3E;
            7'h35: return 8'h3F;
            7'h37: return 8'h2A;
            7'h39: return 8'h20;
            7'h4A: return 8'h2D;
            7'h4E: return 8'h2B;
            default: return CH_NUL;
        endcase
    endfunction

endpackage

`default_nettype wire

FILE: src/sta_if.sv
// handshake interfaces for the scancode input and the character output
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface sta_scan_if;
    logic       valid;
    logic       ready;
    logic [7:0] scancode;
    logic       reader_waiting;

    modport source (output valid, output scancode, output reader_waiting, input ready);
    modport sink   (input valid, input scancode, input reader_waiting, output ready);
endinterface

interface sta_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

FILE: src/sta_front.sv
// front end: keeps prefix, shift and caps flags and classifies each scancode
// depends on sta_pkg
`timescale 1ns / 1ps
`default_nettype none

module sta_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [7:0]    scancode,
    input  wire logic          reader_waiting,
    output logic               push,
    output sta_pkg::cmd_t      push_cmd
);

    logic prefix_reg, prefix_next;
    logic shift_reg, shift_next;
    logic caps_reg, caps_next;

    logic [6:0] key;
    logic [7:0] looked_up;
    logic [7:0] arrow_ch;

    assign key = scancode[6:0];

    always_comb
    begin
        if (shift_reg)
        begin
            looked_up = sta_pkg::shifted_char(key);
        end
        else
        begin
            looked_up = sta_pkg::plain_char(key);
            if (caps_reg && (looked_up inside {[sta_pkg::CH_LOWER_A:sta_pkg::CH_LOWER_Z]}))
            begin
                looked_up = looked_up - sta_pkg::CASE_OFFSET;
            end
        end
    end

    always_comb
    begin
        case (key)
            sta_pkg::SC_UP:    arrow_ch = sta_pkg::CH_UPPER_A;
            sta_pkg::SC_DOWN:  arrow_ch = sta_pkg::CH_UPPER_B;
            sta_pkg::SC_RIGHT: arrow_ch = sta_pkg::CH_UPPER_C;
            sta_pkg::SC_LEFT:  arrow_ch = sta_pkg::CH_UPPER_D;
            default:           arrow_ch = sta_pkg::CH_NUL;
        endcase
    end

    always_comb
    begin
        prefix_next   = prefix_reg;
        shift_next    = shift_reg;
        caps_next     = caps_reg;
        push          = 1'b0;
        push_cmd.kind = sta_pkg::KIND_CHAR;
        push_cmd.ch   = looked_up;
        if (accept)
        begin
            if (scancode == sta_pkg::SC_PREFIX)
            begin
                prefix_next = 1'b1;
            end
            else if (prefix_reg)
            begin
                // extended code: only arrow makes while nobody waits
                prefix_next   = 1'b0;
                push_cmd.kind = sta_pkg::KIND_ARROW;
                push_cmd.ch   = arrow_ch;
                push          = !scancode[7] && !reader_waiting
                                && (arrow_ch != sta_pkg::CH_NUL);
            end
            else if (scancode[7])
            begin
                if (key == sta_pkg::SC_LSHIFT || key == sta_pkg::SC_RSHIFT)
                begin
                    shift_next = 1'b0;
                end
            end
            else if (key == sta_pkg::SC_LSHIFT || key == sta_pkg::SC_RSHIFT)
            begin
                shift_next = 1'b1;
            end
            else if (key == sta_pkg::SC_CAPS)
            begin
                caps_next = !caps_reg;
            end
            else
            begin
                push = (looked_up != sta_pkg::CH_NUL);
                if (looked_up == sta_pkg::CH_BS)
                begin
                    push_cmd.kind = sta_pkg::KIND_BS;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg <= 1'b0;
            shift_reg  <= 1'b0;
            caps_reg   <= 1'b0;
        end
        else
        begin
            prefix_reg <= prefix_next;
            shift_reg  <= shift_next;
            caps_reg   <= caps_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/sta_queue.sv
// short command queue between front and back
// depends on sta_pkg
`timescale 1ns / 1ps
`default_nettype none

module sta_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire sta_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output logic               full,
    output logic               head_valid,
    output sta_pkg::cmd_t      head_cmd
);

    sta_pkg::cmd_t                 mem_reg [sta_pkg::QUEUE_DEPTH];
    logic [sta_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [sta_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [sta_pkg::QCNT_W-1:0]    count_reg, count_next;

    assign full       = (count_reg == sta_pkg::QCNT_W'(sta_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == sta_pkg::QPTR_W'(sta_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == sta_pkg::QPTR_W'(sta_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/sta_back.sv
// back end: expands one command into its output words through an output register
// depends on sta_pkg
`timescale 1ns / 1ps
`default_nettype none

module sta_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          head_valid,
    input  wire sta_pkg::cmd_t head_cmd,
    output logic               pop,
    output logic               out_valid,
    output logic [7:0]         out_character,
    output logic               out_last,
    input  wire logic          out_ready
);

    logic              valid_reg, valid_next;
    logic [7:0]        char_reg, char_next;
    logic              last_reg, last_next;
    sta_pkg::step_t    step_reg, step_next;

    logic [7:0]        word_ch;
    logic              word_last;
    logic              load;

    always_comb
    begin
        word_ch   = head_cmd.ch;
        word_last = 1'b1;
        case (head_cmd.kind)
            sta_pkg::KIND_CHAR:
            begin
                word_ch   = head_cmd.ch;
                word_last = 1'b1;
            end
            sta_pkg::KIND_BS:
            begin
                word_last = (step_reg != '0);
                word_ch   = word_last ? head_cmd.ch : sta_pkg::CH_NUL;
            end
            sta_pkg::KIND_ARROW:
            begin
                case (step_reg)
                    2'd0:    word_ch = sta_pkg::CH_ESC;
                    2'd1:    word_ch = sta_pkg::CH_LBRACKET;
                    default: word_ch = head_cmd.ch;
                endcase
                word_last = (step_reg == 2'd2);
            end
            default:
            begin
                word_ch   = head_cmd.ch;
                word_last = 1'b1;
            end
        endcase
    end

    assign load = head_valid && (!valid_reg || out_ready);
    assign pop  = load && word_last;

    always_comb
    begin
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        step_next  = step_reg;
        if (valid_reg && out_ready)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next = 1'b1;
            char_next  = word_ch;
            last_next  = word_last;
            step_next  = word_last ? '0 : step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid     = valid_reg;
    assign out_character = char_reg;
    assign out_last      = last_reg;

endmodule

`default_nettype wire

FILE: src/scancode_to_ascii_translator.sv
// top level of the ps/2 set-1 scancode to ascii translator
// depends on sta_pkg, sta_if, sta_front, sta_queue, sta_back
`timescale 1ns / 1ps
`default_nettype none

// Translates PS/2 set-1 scancode words into ASCII character words. Each
// scancode gives zero to three characters: a printable key gives one, a
// backspace gives a zero word followed by 0x08, and an arrow key after the
// 0xE0 prefix gives ESC '[' and A/B/C/D. Shift, caps lock, releases and
// unmapped keys change state or are dropped and give no word. The final
// word of each scancode has last set. A scancode is taken in the cycle it
// is offered whenever the two-entry command queue has room, so bursts of
// scancodes go in back to back. The output register sends one character
// per cycle while the reader holds ready, and a scancode produces one
// character for a normal key, two for backspace, three for an arrow key.
// Reset is asynchronous and active low; no clearing pass is needed.

module scancode_to_ascii_translator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    sta_scan_if.sink         scan,
    sta_char_if.source       chars
);

    // front to queue
    logic             push;
    sta_pkg::cmd_t    push_cmd;

    // queue to back
    logic             full;
    logic             head_valid;
    sta_pkg::cmd_t    head_cmd;
    logic             pop;

    logic             accept;

    // input side stalls only when the command queue is full
    assign scan.ready = !full;
    assign accept     = scan.valid && !full;

    // flag tracking and classification
    sta_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .scancode       (scan.scancode),
        .reader_waiting (scan.reader_waiting),
        .push           (push),
        .push_cmd       (push_cmd)
    );

    // decouples the two sides
    sta_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // word expansion and output register
    sta_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_cmd      (head_cmd),
        .pop           (pop),
        .out_valid     (chars.valid),
        .out_character (chars.character),
        .out_last      (chars.last),
        .out_ready     (chars.ready)
    );

endmodule

`default_nettype wire

FILE: src/sta_checker.sv
// port-level checks for the scancode to ascii translator, bound to the top level
// depends on sta_pkg
`timescale 1ns / 1ps
`default_nettype none

module sta_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_character,
    input wire logic       out_last
);

    // a stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_character) && $stable(out_last))
        else $error("stalled output word changed");

    // the zero word before a backspace never ends a sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_character == sta_pkg::CH_NUL) |-> !out_last)
        else $error("zero word marked last");

    // escape only opens an arrow sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_character == sta_pkg::CH_ESC) |-> !out_last)
        else $error("escape word marked last");

    // after escape is taken the bracket follows
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && (out_character == sta_pkg::CH_ESC)
        |=> !out_valid || (out_character == sta_pkg::CH_LBRACKET))
        else $error("escape not followed by bracket");

endmodule

bind scancode_to_ascii_translator sta_checker u_sta_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (chars.valid),
    .out_ready     (chars.ready),
    .out_character (chars.character),
    .out_last      (chars.last)
);

`default_nettype wire

FILE: tb/tb.sv
// self-checking testbench for the ps/2 set-1 scancode to ascii translator
// depends on sta_pkg, sta_if and the translator rtl; nothing else is read
// directed key sequences first, then random typing with random gaps and stalls
`timescale 1ns / 1ps

module tb;
    import sta_pkg::*;

    // one character word as it leaves the block
    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } char_word_t;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 170;
    localparam int DRAIN_CYCLES   = 10;

    logic clk;
    logic rst_n;

    sta_scan_if scan_bus ();
    sta_char_if char_bus ();

    scancode_to_ascii_translator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .scan  (scan_bus),
        .chars (char_bus)
    );

    // keyboard state as the translator should hold it
    logic prefix_pending;
    logic shift_down;
    logic caps_on;

    // characters still owed by the block, oldest first
    char_word_t expected_chars[$];

    int  error_count;
    int  idle_cycles;
    int  words_sent;
    // when set, neither side inserts gaps or stalls
    logic no_idling;

    // 12 ns clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // drive every input to a known value before the first edge
    initial
    begin
        rst_n                   <= 1'b0;
        scan_bus.valid          <= 1'b0;
        scan_bus.scancode       <= 8'h00;
        scan_bus.reader_waiting <= 1'b0;
        char_bus.ready          <= 1'b0;
    end

    // us layout: {shifted, plain} for each make code, zero where unmapped
    function automatic logic [15:0] us_layout(input logic [6:0] key);
        case (key)
            7'h01: return {"~", 8'h60};
            7'h02: return {"!", "1"};
            7'h03: return {"@", "2"};
            7'h04: return {"#", "3"};
            7'h05: return {"$", "4"};
            7'h06: return {"%", "5"};
            7'h07: return {"^", "6"};
            7'h08: return {"&", "7"};
            7'h09: return {"*", "8"};
            7'h0A: return {"(", "9"};
            7'h0B: return {")", "0"};
            7'h0C: return {"_", "-"};
            7'h0D: return {"+", "="};
            7'h0E: return {CH_BS, CH_BS};
            7'h0F: return {8'h09, 8'h09};
            7'h10: return {"Q", "q"};
            7'h11: return {"W", "w"};
            7'h12: return {"E", "e"};
            7'h13: return {"R", "r"};
            7'h14: return {"T", "t"};
            7'h15: return {"Y", "y"};
            7'h16: return {"U", "u"};
            7'h17: return {"I", "i"};
            7'h18: return {"O", "o"};
            7'h19: return {"P", "p"};
            7'h1A: return {"{", "["};
            7'h1B: return {"}", "]"};
            7'h1C: return {8'h0A, 8'h0A};
            7'h1E: return {"A", "a"};
            7'h1F: return {"S", "s"};
            7'h20: return {"D", "d"};
            7'h21: return {"F", "f"};
            7'h22: return {"G", "g"};
            7'h23: return {"H", "h"};
            7'h24: return {"J", "j"};
            7'h25: return {"K", "k"};
            7'h26: return {"L", "l"};
            7'h27: return {":", ";"};
            7'h28: return {8'h22, 8'h27};
            7'h29: return {8'h60, 8'h60};
            7'h2B: return {"|", 8'h5C};
            7'h2C: return {"Z", "z"};
            7'h2D: return {"X", "x"};
            7'h2E: return {"C", "c"};
            7'h2F: return {"V", "v"};
            7'h30: return {"B", "b"};
            7'h31: return {"N", "n"};
            7'h32: return {"M", "m"};
            7'h33: return {"<", ","};
            7'h34: return {">", "."};
            7'h35: return {"?", "/"};
            7'h37: return {"*", "*"};
            7'h39: return {" ", " "};
            7'h4A: return {"-", "-"};
            7'h4E: return {"+", "+"};
            default: return 16'h0000;
        endcase
    endfunction

    // queue one expected word
    task automatic owe_char(input logic [7:0] ch, input logic is_last);
        char_word_t w;
        w.character = ch;
        w.last      = is_last;
        expected_chars.push_back(w);
    endtask

    // update keyboard state for one accepted scancode and queue its characters
    task automatic translate_scancode(input logic [7:0] code, input logic waiting);
        logic [15:0] pair;
        logic [7:0]  ch;
        logic [7:0]  arrow;
        arrow = CH_NUL;
        if (code == SC_PREFIX)
        begin
            prefix_pending = 1'b1;
        end
        else if (prefix_pending)
        begin
            // only an arrow make with no reader waiting survives the prefix
            prefix_pending = 1'b0;
            if (!code[7] && !waiting)
            begin
                case (code[6:0])
                    SC_UP:    arrow = CH_UPPER_A;
                    SC_DOWN:  arrow = CH_UPPER_B;
                    SC_RIGHT: arrow = CH_UPPER_C;
                    SC_LEFT:  arrow = CH_UPPER_D;
                    default:  arrow = CH_NUL;
                endcase
                if (arrow != CH_NUL)
                begin
                    owe_char(CH_ESC, 1'b0);
                    owe_char(CH_LBRACKET, 1'b0);
                    owe_char(arrow, 1'b1);
                end
            end
        end
        else if (code[7])
        begin
            // releases only matter for the shift keys
            if (code[6:0] == SC_LSHIFT || code[6:0] == SC_RSHIFT)
                shift_down = 1'b0;
        end
        else if (code[6:0] == SC_LSHIFT || code[6:0] == SC_RSHIFT)
        begin
            shift_down = 1'b1;
        end
        else if (code[6:0] == SC_CAPS)
        begin
            caps_on = ~caps_on;
        end
        else
        begin
            pair = us_layout(code[6:0]);
            if (shift_down)
            begin
                ch = pair[15:8];
            end
            else
            begin
                ch = pair[7:0];
                if (caps_on && ch >= CH_LOWER_A && ch <= CH_LOWER_Z)
                    ch = ch - CASE_OFFSET;
            end
            if (ch == CH_BS)
                owe_char(CH_NUL, 1'b0);
            if (ch != CH_NUL)
                owe_char(ch, 1'b1);
        end
    endtask

    // offer one scancode word; valid is only lowered when a gap is drawn,
    // so back-to-back words keep it high across the accepting edge
    task automatic send_scancode(input logic [7:0] code, input logic waiting);
        int gap;
        gap = no_idling ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            scan_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        scan_bus.valid          <= 1'b1;
        scan_bus.scancode       <= code;
        scan_bus.reader_waiting <= waiting;
        @(posedge clk);
        while (!scan_bus.ready)
            @(posedge clk);
        translate_scancode(code, waiting);
        words_sent++;
    endtask

    // an arrow key: prefix then make code
    task automatic send_arrow(input logic [6:0] key, input logic waiting);
        send_scancode(SC_PREFIX, 1'($urandom_range(0, 1)));
        send_scancode({1'b0, key}, waiting);
    endtask

    // table extremes, unmapped codes, releases, keypad and backspace
    task automatic test_extremes();
        send_scancode(8'h00, 1'b0);
        send_scancode(8'h7F, 1'b1);
        send_scancode(8'h80, 1'b0);
        send_scancode(8'hFF, 1'b1);
        send_scancode(8'h0E, 1'b0);
        send_scancode(8'h4A, 1'b0);
        send_scancode(8'h4E, 1'b1);
    endtask

    // shift from both keys, caps lock, and shift taking priority over caps
    task automatic test_modifiers();
        send_scancode({1'b0, SC_LSHIFT}, 1'b0);
        send_scancode(8'h1E, 1'b0);
        send_scancode({1'b1, SC_LSHIFT}, 1'b0);
        send_scancode({1'b0, SC_CAPS}, 1'b0);
        send_scancode(8'h1E, 1'b0);
        send_scancode({1'b0, SC_RSHIFT}, 1'b0);
        send_scancode(8'h1E, 1'b0);
        send_scancode({1'b1, SC_RSHIFT}, 1'b0);
        send_scancode({1'b0, SC_CAPS}, 1'b0);
    endtask

    // the four arrows, then the ways a prefix is swallowed without output
    task automatic test_arrows();
        send_arrow(SC_UP, 1'b0);
        send_arrow(SC_DOWN, 1'b0);
        send_arrow(SC_RIGHT, 1'b0);
        send_arrow(SC_LEFT, 1'b0);
        // double prefix then a prefixed release
        send_scancode(SC_PREFIX, 1'b0);
        send_scancode(SC_PREFIX, 1'b0);
        send_scancode({1'b1, SC_UP}, 1'b0);
        // arrow dropped while a reader waits
        send_arrow(SC_LEFT, 1'b1);
        // prefixed key that is not an arrow
        send_scancode(SC_PREFIX, 1'b0);
        send_scancode(8'h1E, 1'b0);
    endtask

    // mostly well-formed typing with random content, some raw noise
    task automatic test_random_typing();
        int          pick;
        int          n_keys;
        logic [6:0]  arrows[4];
        arrows = '{SC_UP, SC_DOWN, SC_RIGHT, SC_LEFT};
        while (words_sent < RANDOM_ITEMS)
        begin
            // switch between idling and full-speed stretches now and then
            if ($urandom_range(0, 29) == 0)
                no_idling = ~no_idling;
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                send_scancode({1'b0, 7'($urandom_range(0, 127))}, 1'($urandom_range(0, 1)));
            end
            else if (pick < 55)
            begin
                // shifted burst, released by either shift key
                send_scancode({1'b0, ($urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT)}, 1'b0);
                n_keys = $urandom_range(1, 3);
                repeat (n_keys)
                    send_scancode({1'b0, 7'($urandom_range(0, 127))},
                                  1'($urandom_range(0, 1)));
                send_scancode({1'b1, ($urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT)}, 1'b0);
            end
            else if (pick < 62)
            begin
                send_scancode({1'b0, SC_CAPS}, 1'($urandom_range(0, 1)));
            end
            else if (pick < 80)
            begin
                send_arrow(arrows[2'($urandom_range(0, 3))], $urandom_range(0, 9) == 0);
            end
            else if (pick < 88)
            begin
                // prefix followed by anything
                send_scancode(SC_PREFIX, 1'($urandom_range(0, 1)));
                send_scancode(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            else
            begin
                send_scancode(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // character sink: random stalls, checks every accepted word in order
    initial
    begin : char_sink
        int         stall;
        char_word_t want;
        @(posedge rst_n);
        forever
        begin
            stall = no_idling ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                char_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            char_bus.ready <= 1'b1;
            @(posedge clk);
            while (!char_bus.valid)
                @(posedge clk);
            if (expected_chars.size() == 0)
            begin
                $display("%0t: unexpected word character=%02h last=%0b", $time,
                         char_bus.character, char_bus.last);
                error_count++;
            end
            else
            begin
                want = expected_chars.pop_front();
                if (char_bus.character !== want.character)
                begin
                    $display("%0t: character expected %02h actual %02h", $time,
                             want.character, char_bus.character);
                    error_count++;
                end
                if (char_bus.last !== want.last)
                begin
                    $display("%0t: last expected %0b actual %0b", $time,
                             want.last, char_bus.last);
                    error_count++;
                end
            end
        end
    end

    // watchdog: too long without any word moving on either side
    always @(posedge clk)
    begin
        if ((scan_bus.valid && scan_bus.ready) || (char_bus.valid && char_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // main sequence
    initial
    begin
        prefix_pending = 1'b0;
        shift_down     = 1'b0;
        caps_on        = 1'b0;
        error_count    = 0;
        idle_cycles    = 0;
        words_sent     = 0;
        no_idling      = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_modifiers();
        test_arrows();
        words_sent = 0;
        test_random_typing();

        scan_bus.valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        // let any straggler show up as an unexpected word
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
